// File: src/tesd_pkg.sv
package tesd_pkg;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_ESC   = 10'b00_0000_0010,
    PH_SS3   = 10'b00_0000_0100,
    PH_CSI   = 10'b00_0000_1000,
    PH_CSI1  = 10'b00_0001_0000,
    PH_CSI2  = 10'b00_0010_0000,
    PH_TILDE = 10'b00_0100_0000,
    PH_MB    = 10'b00_1000_0000,
    PH_MX    = 10'b01_0000_0000,
    PH_MY    = 10'b10_0000_0000
  } phase_t;

  localparam logic [1:0] EV_KEY     = 2'd0;
  localparam logic [1:0] EV_MOUSE   = 2'd1;
  localparam logic [1:0] EV_UNKNOWN = 2'd2;

  localparam logic [8:0] KC_F1    = 9'd256;
  localparam logic [8:0] KC_F5    = 9'd260;
  localparam logic [8:0] KC_F6    = 9'd261;
  localparam logic [8:0] KC_F7    = 9'd262;
  localparam logic [8:0] KC_F8    = 9'd263;
  localparam logic [8:0] KC_F9    = 9'd264;
  localparam logic [8:0] KC_F10   = 9'd265;
  localparam logic [8:0] KC_F11   = 9'd266;
  localparam logic [8:0] KC_F12   = 9'd267;
  localparam logic [8:0] KC_DEL   = 9'd268;
  localparam logic [8:0] KC_UP    = 9'd269;
  localparam logic [8:0] KC_ERROR = 9'd273;

  localparam logic [2:0] MA_OTHER    = 3'd0;
  localparam logic [2:0] MA_DOWN     = 3'd1;
  localparam logic [2:0] MA_UP       = 3'd2;
  localparam logic [2:0] MA_SCROLL_U = 3'd3;
  localparam logic [2:0] MA_SCROLL_D = 3'd4;
  localparam logic [2:0] MA_MOVE     = 3'd5;

  localparam logic [1:0] MB_NONE   = 2'd0;
  localparam logic [1:0] MB_LEFT   = 2'd1;
  localparam logic [1:0] MB_MIDDLE = 2'd2;
  localparam logic [1:0] MB_RIGHT  = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_CSI   = 8'd91;
  localparam logic [7:0] CH_SS3   = 8'd79;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_M_UP  = 8'd77;
  localparam logic [7:0] CH_M_LO  = 8'd109;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_ONE   = 8'd49;
  localparam logic [7:0] CH_TWO   = 8'd50;
  localparam logic [7:0] CH_THREE = 8'd51;
  localparam logic [7:0] CH_FOUR  = 8'd52;
  localparam logic [7:0] CH_FIVE  = 8'd53;
  localparam logic [7:0] CH_SEVEN = 8'd55;
  localparam logic [7:0] CH_EIGHT = 8'd56;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_D     = 8'd68;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_S     = 8'd83;

  localparam logic [7:0] MC_LEFT        = 8'd0;
  localparam logic [7:0] MC_MIDDLE      = 8'd1;
  localparam logic [7:0] MC_RIGHT       = 8'd2;
  localparam logic [7:0] MC_MOVE_LEFT   = 8'd32;
  localparam logic [7:0] MC_MOVE_RIGHT  = 8'd34;
  localparam logic [7:0] MC_MOVE_NONE   = 8'd35;
  localparam logic [7:0] MC_MOVE_MIDDLE = 8'd36;
  localparam logic [7:0] MC_SCROLL_UP   = 8'd64;
  localparam logic [7:0] MC_SCROLL_DOWN = 8'd65;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [8:0]  key_code;
    logic [2:0]  mouse_action;
    logic [1:0]  mouse_button;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
  } res_t;

endpackage

// File: src/terminal_escape_sequence_decoder_core.sv
// Decodes a stream of terminal input bytes into key, SGR mouse and
// unrecognized-sequence events, one byte per cycle unless a held output stalls
// the input side. Each byte is captured in an input register, run through the
// escape-sequence parser, and any event it yields lands in an output register;
// a byte that ends a sequence yields at most one event, bytes inside a
// sequence yield none. Input ready stays high while the output register is
// empty or being taken, so stalls on the output only hold the input side when
// a waiting byte would produce another event.
module terminal_escape_sequence_decoder_core import tesd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_batch_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [8:0]  out_key_code,
  output logic [2:0]  out_mouse_action,
  output logic [1:0]  out_mouse_button,
  output logic [15:0] out_mouse_x,
  output logic [15:0] out_mouse_y
);

  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_last;
  logic       res_valid;
  res_t       res;
  logic       out_free;
  logic       advance;
  res_t       out_res;

  assign advance  = inq_valid && (!res_valid || out_free);
  assign in_ready = !inq_valid || advance;

  tesd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_valid && in_ready),
    .advance (advance),
    .byte_i  (in_byte),
    .last_i  (in_batch_end),
    .valid_o (inq_valid),
    .byte_o  (inq_byte),
    .last_o  (inq_last)
  );

  tesd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .byte_i    (inq_byte),
    .last_i    (inq_last),
    .res_valid (res_valid),
    .res       (res)
  );

  tesd_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance && res_valid),
    .res_i   (res),
    .ready_i (out_ready),
    .free_o  (out_free),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign out_event_kind   = out_res.event_kind;
  assign out_key_code     = out_res.key_code;
  assign out_mouse_action = out_res.mouse_action;
  assign out_mouse_button = out_res.mouse_button;
  assign out_mouse_x      = out_res.mouse_x;
  assign out_mouse_y      = out_res.mouse_y;

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !inq_valid |-> in_ready)
    else $error("input stage empty but not ready");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    inq_valid && res_valid && out_valid && !out_ready |-> !advance)
    else $error("pending event would overwrite held output");

  a_mouse_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_MOUSE |-> out_key_code == '0)
    else $error("mouse event carries a key code");

  a_key_no_mouse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_MOUSE |->
      out_mouse_x == '0 && out_mouse_y == '0 && out_mouse_action == MA_OTHER)
    else $error("non-mouse event carries mouse fields");

endmodule

// File: src/tesd_in_stage.sv
module tesd_in_stage import tesd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       advance,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_i;
      last_r <= last_i;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;
  assign last_o  = last_r;

endmodule

// File: src/tesd_parser.sv
module tesd_parser import tesd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       res_valid,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  btn_r, btn_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [8:0]  pend_r, pend_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] btn_v;
  logic [19:0] col_v;
  logic [19:0] row_v;
  logic [7:0]  btn_sat;
  logic [15:0] col_sat;
  logic [15:0] row_sat;
  res_t        err_res;
  res_t        mouse_res;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = 4'(byte_i - CH_ZERO);

  assign btn_v   = 12'(btn_r) * 12'd10 + 12'(digit);
  assign col_v   = 20'(col_r) * 20'd10 + 20'(digit);
  assign row_v   = 20'(row_r) * 20'd10 + 20'(digit);
  assign btn_sat = (btn_v > 12'd255)    ? 8'hFF    : btn_v[7:0];
  assign col_sat = (col_v > 20'hFFFF)   ? 16'hFFFF : col_v[15:0];
  assign row_sat = (row_v > 20'hFFFF)   ? 16'hFFFF : row_v[15:0];

  always_comb begin
    err_res          = '0;
    err_res.key_code = KC_ERROR;
  end

  always_comb begin
    mouse_res            = '0;
    mouse_res.event_kind = EV_MOUSE;
    mouse_res.mouse_x    = col_r;
    mouse_res.mouse_y    = row_r;
    case (btn_r)
      MC_LEFT, MC_MIDDLE, MC_RIGHT: begin
        mouse_res.mouse_action = (byte_i == CH_M_UP) ? MA_DOWN : MA_UP;
        mouse_res.mouse_button = (btn_r == MC_LEFT) ? MB_LEFT :
                                 (btn_r == MC_MIDDLE) ? MB_MIDDLE : MB_RIGHT;
      end
      MC_SCROLL_UP:   mouse_res.mouse_action = MA_SCROLL_U;
      MC_SCROLL_DOWN: mouse_res.mouse_action = MA_SCROLL_D;
      MC_MOVE_NONE:   mouse_res.mouse_action = MA_MOVE;
      MC_MOVE_LEFT: begin
        mouse_res.mouse_action = MA_MOVE;
        mouse_res.mouse_button = MB_LEFT;
      end
      MC_MOVE_RIGHT: begin
        mouse_res.mouse_action = MA_MOVE;
        mouse_res.mouse_button = MB_RIGHT;
      end
      MC_MOVE_MIDDLE: begin
        mouse_res.mouse_action = MA_MOVE;
        mouse_res.mouse_button = MB_MIDDLE;
      end
      default: mouse_res.mouse_action = MA_OTHER;
    endcase
  end

  always_comb begin
    phase_nxt = PH_IDLE;
    btn_nxt   = btn_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_ESC: begin
        if (byte_i == CH_CSI) begin
          phase_nxt = PH_CSI;
        end else if (byte_i == CH_SS3) begin
          phase_nxt = PH_SS3;
        end else begin
          res_valid      = 1'b1;
          res.event_kind = EV_UNKNOWN;
        end
      end
      PH_SS3: begin
        res_valid = 1'b1;
        if (byte_i inside {[CH_P:CH_S]}) begin
          res.key_code = KC_F1 + {7'd0, byte_i[1:0]};
        end else begin
          res = err_res;
        end
      end
      PH_CSI: begin
        if (byte_i == CH_LT) begin
          btn_nxt   = '0;
          col_nxt   = '0;
          row_nxt   = '0;
          phase_nxt = PH_MB;
        end else if (byte_i inside {[CH_A:CH_D]}) begin
          res_valid    = 1'b1;
          res.key_code = KC_UP + {1'b0, byte_i - CH_A};
        end else if (byte_i == CH_THREE) begin
          pend_nxt  = KC_DEL;
          phase_nxt = PH_TILDE;
        end else if (byte_i == CH_ONE) begin
          phase_nxt = PH_CSI1;
        end else if (byte_i == CH_TWO) begin
          phase_nxt = PH_CSI2;
        end else begin
          res_valid = 1'b1;
          res       = err_res;
        end
      end
      PH_CSI1: begin
        phase_nxt = PH_TILDE;
        case (byte_i)
          CH_FIVE:  pend_nxt = KC_F5;
          CH_SEVEN: pend_nxt = KC_F6;
          CH_EIGHT: pend_nxt = KC_F7;
          CH_NINE:  pend_nxt = KC_F8;
          default: begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res       = err_res;
          end
        endcase
      end
      PH_CSI2: begin
        phase_nxt = PH_TILDE;
        case (byte_i)
          CH_ZERO:  pend_nxt = KC_F9;
          CH_ONE:   pend_nxt = KC_F10;
          CH_THREE: pend_nxt = KC_F11;
          CH_FOUR:  pend_nxt = KC_F12;
          default: begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res       = err_res;
          end
        endcase
      end
      PH_TILDE: begin
        res_valid    = 1'b1;
        res.key_code = pend_r;
      end
      PH_MB: begin
        if (byte_i == CH_SEMI) begin
          phase_nxt = PH_MX;
        end else if (is_digit) begin
          btn_nxt   = btn_sat;
          phase_nxt = PH_MB;
        end else begin
          res_valid = 1'b1;
          res       = err_res;
        end
      end
      PH_MX: begin
        if (byte_i == CH_SEMI) begin
          phase_nxt = PH_MY;
        end else if (is_digit) begin
          col_nxt   = col_sat;
          phase_nxt = PH_MX;
        end else begin
          res_valid = 1'b1;
          res       = err_res;
        end
      end
      PH_MY: begin
        if (byte_i == CH_M_UP || byte_i == CH_M_LO) begin
          res_valid = 1'b1;
          res       = mouse_res;
        end else if (is_digit) begin
          row_nxt   = row_sat;
          phase_nxt = PH_MY;
        end else begin
          res_valid = 1'b1;
          res       = err_res;
        end
      end
      default: begin
        if (byte_i != CH_ESC || last_i) begin
          res_valid    = 1'b1;
          res.key_code = {1'b0, byte_i};
        end else begin
          phase_nxt = PH_ESC;
        end
      end
    endcase
    // cut sequence: flag error and drop back to idle
    if (!res_valid && phase_nxt != PH_IDLE && last_i) begin
      res_valid = 1'b1;
      res       = err_res;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      btn_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      btn_r   <= btn_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// File: src/tesd_out_stage.sv
module tesd_out_stage import tesd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_i,
  input  logic ready_i,
  output logic free_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_r;
  res_t res_r;

  assign free_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (ready_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_i;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule
